/* src/bbl_pkg.sv */
package bbl_pkg;

	localparam int COEF_BITS       = 19;
	localparam int HIST_FRAC       = 8;
	localparam int ACC_FRAC        = 24;
	localparam int CHAN_BITS       = 3;
	localparam int REG_IDX_BITS    = 2;
	localparam int DEF_CHANNELS    = 8;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int RESULT_DEPTH    = 8;

	localparam logic signed [COEF_BITS-1:0] GAIN_RST   = 19'sd4421;
	localparam logic signed [COEF_BITS-1:0] FB_ONE_RST = -19'sd74906;
	localparam logic signed [COEF_BITS-1:0] FB_TWO_RST = 19'sd27054;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_GAIN   = 2'd0,
		REG_FB_ONE = 2'd1,
		REG_FB_TWO = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] gain;
		logic signed [COEF_BITS-1:0] fb_one;
		logic signed [COEF_BITS-1:0] fb_two;
	} coef_t;

endpackage

/* src/butterworth_biquad_lowpass.sv */
// Multichannel second-order Butterworth low-pass biquad, direct form I.
// Input channel: push/full. A beat carries sample and channel and is taken
// when push is high and full is low. A beat whose channel has no state is
// taken and dropped without a result.
// Result channel: empty/pop. The oldest result (filtered, out_channel,
// clipped) is shown while empty is low and leaves when pop is high.
// Configuration: write_en, write_index, write_data load the Q3.16 gain and
// feedback coefficients; write only while the block is idle.
// An accepted beat passes the input queue, stages s1 to s3 and the result queue.
// Throughput: one beat per cycle while the result queue has room and no beat of
// the same channel is still in flight; a channel's state is read only after
// the previous write-back of the 3-stage multiply-add pipe.
// A 4-entry input queue and an 8-entry result queue decouple the two sides;
// when pop stays low the result queue fills, issue stops, then full rises.
// Reset clears the coefficients to their defaults and marks all channel history
// as zero at once; beats are accepted in the first cycle after reset.
module butterworth_biquad_lowpass #(
	parameter int CHANNELS    = bbl_pkg::DEF_CHANNELS,
	parameter int SAMPLE_BITS = bbl_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  logic [bbl_pkg::CHAN_BITS-1:0]         channel,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [SAMPLE_BITS-1:0]         filtered,
	output logic [bbl_pkg::CHAN_BITS-1:0]         out_channel,
	output logic                                  clipped,
	input  logic                                  write_en,
	input  logic [bbl_pkg::REG_IDX_BITS-1:0]      write_index,
	input  logic [bbl_pkg::COEF_BITS-1:0]         write_data
);

	bbl_pkg::coef_t                      coef_q;
	logic                                q_pop;
	logic                                q_empty;
	logic signed [SAMPLE_BITS-1:0]       q_sample;
	logic [bbl_pkg::CHAN_BITS-1:0]       q_channel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.gain   <= bbl_pkg::GAIN_RST;
			coef_q.fb_one <= bbl_pkg::FB_ONE_RST;
			coef_q.fb_two <= bbl_pkg::FB_TWO_RST;
		end else if (write_en) begin
			case (bbl_pkg::reg_idx_t'(write_index))
				bbl_pkg::REG_GAIN: begin
					coef_q.gain <= write_data;
				end
				bbl_pkg::REG_FB_ONE: begin
					coef_q.fb_one <= write_data;
				end
				bbl_pkg::REG_FB_TWO: begin
					coef_q.fb_two <= write_data;
				end
				default: begin
				end
			endcase
		end
	end

	bbl_front #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.channel   (channel),
		.q_pop     (q_pop),
		.q_empty   (q_empty),
		.q_sample  (q_sample),
		.q_channel (q_channel)
	);

	bbl_back #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.coef        (coef_q),
		.q_empty     (q_empty),
		.q_sample    (q_sample),
		.q_channel   (q_channel),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.filtered    (filtered),
		.out_channel (out_channel),
		.clipped     (clipped)
	);

endmodule

/* src/bbl_fifo.sv */
module bbl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           pop_data,
	output logic                       empty,
	output logic [$clog2(DEPTH):0]     count
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (!push && pop) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = entry_q[rd_ptr_q];
	assign empty    = (count_q == '0);
	assign count    = count_q;

endmodule

/* src/bbl_front.sv */
module bbl_front #(
	parameter int CHANNELS    = bbl_pkg::DEF_CHANNELS,
	parameter int SAMPLE_BITS = bbl_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic [bbl_pkg::CHAN_BITS-1:0]       channel,
	input  logic                                q_pop,
	output logic                                q_empty,
	output logic signed [SAMPLE_BITS-1:0]       q_sample,
	output logic [bbl_pkg::CHAN_BITS-1:0]       q_channel
);

	localparam int CH_W  = bbl_pkg::CHAN_BITS;
	localparam int W     = SAMPLE_BITS + CH_W;
	localparam int DEPTH = bbl_pkg::QUEUE_DEPTH;
	localparam int CNT_W = $clog2(DEPTH) + 1;

	logic             in_range;
	logic             q_push;
	logic [W-1:0]     q_data;
	logic [CNT_W-1:0] q_count;

	// drop beats whose channel has no filter state
	assign in_range = (32'(channel) < 32'(CHANNELS));
	assign full     = (q_count == CNT_W'(DEPTH));
	assign q_push   = push && !full && in_range;

	bbl_fifo #(
		.WIDTH (W),
		.DEPTH (DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({channel, sample}),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty),
		.count     (q_count)
	);

	assign q_sample  = q_data[SAMPLE_BITS-1:0];
	assign q_channel = q_data[W-1 -: CH_W];

endmodule

/* src/bbl_back.sv */
module bbl_back #(
	parameter int CHANNELS    = bbl_pkg::DEF_CHANNELS,
	parameter int SAMPLE_BITS = bbl_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bbl_pkg::coef_t                      coef,
	input  logic                                q_empty,
	input  logic signed [SAMPLE_BITS-1:0]       q_sample,
	input  logic [bbl_pkg::CHAN_BITS-1:0]       q_channel,
	output logic                                q_pop,
	input  logic                                pop,
	output logic                                empty,
	output logic signed [SAMPLE_BITS-1:0]       filtered,
	output logic [bbl_pkg::CHAN_BITS-1:0]       out_channel,
	output logic                                clipped
);

	localparam int SB      = SAMPLE_BITS;
	localparam int CH_W    = bbl_pkg::CHAN_BITS;
	localparam int COEF_W  = bbl_pkg::COEF_BITS;
	localparam int HW      = SAMPLE_BITS + bbl_pkg::HIST_FRAC;
	localparam int NUM_W   = SAMPLE_BITS + 2;
	localparam int P0_W    = COEF_W + NUM_W;
	localparam int P1_W    = COEF_W + HW;
	localparam int ACC_W   = COEF_W + SAMPLE_BITS + 10;
	localparam int RND_W   = ACC_W + 1;
	localparam int HSH     = bbl_pkg::ACC_FRAC - bbl_pkg::HIST_FRAC;
	localparam int YSH     = bbl_pkg::ACC_FRAC;
	localparam int IW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STATE_W = 2 * SAMPLE_BITS + 2 * HW;
	localparam int OUT_W   = SAMPLE_BITS + CH_W + 1;
	localparam int ODEPTH  = bbl_pkg::RESULT_DEPTH;
	localparam int OCNT_W  = $clog2(ODEPTH) + 1;
	localparam int CRED_W  = OCNT_W + 1;

	localparam logic signed [RND_W-1:0] H_HALF = RND_W'(1) <<< (HSH - 1);
	localparam logic signed [RND_W-1:0] Y_HALF = RND_W'(1) <<< (YSH - 1);
	localparam logic signed [RND_W-1:0] H_MAX  = (RND_W'(1) <<< (HW - 1)) - RND_W'(1);
	localparam logic signed [RND_W-1:0] H_MIN  = -H_MAX - RND_W'(1);
	localparam logic signed [RND_W-1:0] Y_MAX  = (RND_W'(1) <<< (SB - 1)) - RND_W'(1);
	localparam logic signed [RND_W-1:0] Y_MIN  = -Y_MAX - RND_W'(1);

	logic [STATE_W-1:0] state_mem [CHANNELS];
	logic [CHANNELS-1:0] chan_ok_q;

	logic                   issue;
	logic                   hazard;
	logic                   credit_ok;
	logic [OCNT_W-1:0]      out_count;

	logic                   v_s1;
	logic [CH_W-1:0]        ch_s1;
	logic signed [SB-1:0]   smp_s1;
	logic [STATE_W-1:0]     st_s1;
	logic                   ok_s1;

	logic signed [SB-1:0]   u1_rd;
	logic signed [SB-1:0]   u2_rd;
	logic signed [HW-1:0]   y1_rd;
	logic signed [HW-1:0]   y2_rd;
	logic signed [NUM_W-1:0] num;

	logic                   v_s2;
	logic [CH_W-1:0]        ch_s2;
	logic signed [SB-1:0]   smp_s2;
	logic signed [SB-1:0]   u1_s2;
	logic signed [HW-1:0]   y1_s2;
	logic signed [P0_W-1:0] p0_s2;
	logic signed [P1_W-1:0] p1_s2;
	logic signed [P1_W-1:0] p2_s2;

	logic                    v_s3;
	logic [CH_W-1:0]         ch_s3;
	logic signed [SB-1:0]    smp_s3;
	logic signed [SB-1:0]    u1_s3;
	logic signed [HW-1:0]    y1_s3;
	logic signed [ACC_W-1:0] acc_s3;

	logic signed [RND_W-1:0] acc_x;
	logic signed [RND_W-1:0] h_rnd;
	logic signed [RND_W-1:0] y_rnd;
	logic signed [HW-1:0]    hist;
	logic signed [SB-1:0]    y_sat;
	logic                    clip;
	logic [IW-1:0]           wb_idx;
	logic [OUT_W-1:0]        out_data;

	// hold a beat while its channel is still in flight or the result queue lacks room
	assign hazard = (v_s1 && (ch_s1 == q_channel)) ||
	                (v_s2 && (ch_s2 == q_channel)) ||
	                (v_s3 && (ch_s3 == q_channel));
	assign credit_ok = (CRED_W'(out_count) + CRED_W'(v_s1) + CRED_W'(v_s2) + CRED_W'(v_s3))
	                   < CRED_W'(ODEPTH);
	assign issue = !q_empty && !hazard && credit_ok;
	assign q_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			chan_ok_q <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				chan_ok_q[wb_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			st_s1 <= state_mem[IW'(q_channel)];
		end
		if (v_s3) begin
			state_mem[wb_idx] <= {smp_s3, u1_s3, hist, y1_s3};
		end
	end

	always_ff @(posedge clk) begin
		ch_s1  <= q_channel;
		smp_s1 <= q_sample;
		ok_s1  <= chan_ok_q[IW'(q_channel)];

		ch_s2  <= ch_s1;
		smp_s2 <= smp_s1;
		u1_s2  <= u1_rd;
		y1_s2  <= y1_rd;
		p0_s2  <= P0_W'(coef.gain) * P0_W'(num);
		p1_s2  <= P1_W'(coef.fb_one) * P1_W'(y1_rd);
		p2_s2  <= P1_W'(coef.fb_two) * P1_W'(y2_rd);

		ch_s3  <= ch_s2;
		smp_s3 <= smp_s2;
		u1_s3  <= u1_s2;
		y1_s3  <= y1_s2;
		acc_s3 <= (ACC_W'(p0_s2) <<< bbl_pkg::HIST_FRAC) - ACC_W'(p1_s2) - ACC_W'(p2_s2);
	end

	assign u1_rd = ok_s1 ? st_s1[STATE_W-1 -: SB]  : '0;
	assign u2_rd = ok_s1 ? st_s1[2*HW+SB-1 -: SB]  : '0;
	assign y1_rd = ok_s1 ? st_s1[2*HW-1 -: HW]     : '0;
	assign y2_rd = ok_s1 ? st_s1[HW-1:0]           : '0;
	assign num   = NUM_W'(smp_s1) + (NUM_W'(u1_rd) <<< 1) + NUM_W'(u2_rd);

	assign acc_x = RND_W'(acc_s3);
	assign h_rnd = (acc_x + H_HALF) >>> HSH;
	assign y_rnd = (acc_x + Y_HALF) >>> YSH;

	always_comb begin
		if (h_rnd > H_MAX) begin
			hist = H_MAX[HW-1:0];
		end else if (h_rnd < H_MIN) begin
			hist = H_MIN[HW-1:0];
		end else begin
			hist = h_rnd[HW-1:0];
		end
		clip = 1'b0;
		if (y_rnd > Y_MAX) begin
			y_sat = Y_MAX[SB-1:0];
			clip  = 1'b1;
		end else if (y_rnd < Y_MIN) begin
			y_sat = Y_MIN[SB-1:0];
			clip  = 1'b1;
		end else begin
			y_sat = y_rnd[SB-1:0];
		end
	end

	assign wb_idx = IW'(ch_s3);

	bbl_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (ODEPTH)
	) u_results (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_data ({clip, ch_s3, y_sat}),
		.pop       (pop && !empty),
		.pop_data  (out_data),
		.empty     (empty),
		.count     (out_count)
	);

	assign clipped     = out_data[OUT_W-1];
	assign out_channel = out_data[OUT_W-2 -: CH_W];
	assign filtered    = out_data[SB-1:0];

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (out_count < OCNT_W'(ODEPTH)))
		else $error("result queue overrun");

	a_s1_s2_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2) |-> (ch_s1 != ch_s2))
		else $error("same channel in adjacent stages");

	a_late_apart: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ((!v_s2 || (ch_s2 != ch_s3)) && (!v_s1 || (ch_s1 != ch_s3))))
		else $error("channel issued before its write-back");

	a_issue_src: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("issue from empty queue");

endmodule
